### design/scba_pkg.sv
// ----------------------------------------------------------------------------
// scba_pkg
// Shared widths, constants and codes of the size-class block allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

  localparam int unsigned SIZE_W     = 32;
  localparam int unsigned CLASS_W    = 5;
  localparam int unsigned PAGE_W     = 4;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned ENTRY_W    = PAGE_W + SLOT_W;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [SIZE_W-1:0] MIN_BLOCK = 32'd256;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANT     = 3'd0,
    ST_OVERSIZE  = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_UNPOOLED  = 3'd3,
    ST_INVALID   = 3'd4,
    ST_EXHAUSTED = 3'd5
  } status_e;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

endpackage

### design/scba_size_class.sv
// ----------------------------------------------------------------------------
// scba_size_class
// Rounds a byte size up to its power-of-two size class.
// ----------------------------------------------------------------------------
module scba_size_class #(
  parameter int unsigned NUM_CLASSES = 17
) (
  input  logic [scba_pkg::SIZE_W-1:0]  size_i,
  output logic [scba_pkg::CLASS_W-1:0] class_o,
  output logic                         oversize_o
);
  import scba_pkg::*;

  always_comb begin
    class_o    = '0;
    oversize_o = 1'b1;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (size_i <= (MIN_BLOCK << c)) begin
        class_o    = CLASS_W'(c);
        oversize_o = 1'b0;
      end
    end
  end

endmodule

### design/scba_meta_mem.sv
// ----------------------------------------------------------------------------
// scba_meta_mem
// Per-class metadata memory, registered read, entries read as zero until written.
// ----------------------------------------------------------------------------
module scba_meta_mem #(
  parameter int unsigned DEPTH = 17,
  parameter int unsigned AW    = 5,
  parameter int unsigned W     = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [W-1:0]  rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [W-1:0]  wr_data_i
);

  logic [W-1:0]     mem_q [DEPTH];
  logic [W-1:0]     data_q;
  logic [DEPTH-1:0] valid_q;
  logic             hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = hit_q ? data_q : '0;

endmodule

### design/scba_stack_mem.sv
// ----------------------------------------------------------------------------
// scba_stack_mem
// Free-handle stack storage for all classes, registered read.
// ----------------------------------------------------------------------------
module scba_stack_mem #(
  parameter int unsigned DEPTH = 17408,
  parameter int unsigned AW    = 15,
  parameter int unsigned W     = 10
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [W-1:0]  rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [W-1:0]  wr_data_i
);

  logic [W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

### design/size_class_block_allocator.sv
// ----------------------------------------------------------------------------
// size_class_block_allocator
// Segregated free-list allocator handing out (page, slot) handles per class.
// ----------------------------------------------------------------------------
// One request is taken at a time. The transfer in reads the class metadata
// memory (stack depth, pages made, untouched slots of the newest page).
// The next cycle decides, writes the metadata back and loads the result
// register. The result is offered from the result register, and the next
// request can be taken in the same cycle as the result is offered. An
// allocate served from the free stack passes through an extra state for
// the read of the stack memory. A result that still waits holds the block
// in its last state until the result register frees up.
// The result register lets a new request be taken while a result still waits.
// Metadata entries read as zero until first written, so no clearing pass
// follows reset; stack entries are only read below the stack depth.
module size_class_block_allocator #(
  parameter int unsigned NUM_CLASSES = 17,
  parameter int unsigned MAX_PAGES   = 16,
  parameter int unsigned MAX_SLOTS   = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // req_size[31:0], is_pooled[32], rel_page[36:33], rel_slot[42:37], zeros
  input  logic [scba_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // cmd
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // class_index[4:0], blk_size[36:5], page_num[40:37],
  // slot_index[46:41], pooled[47]
  output logic [scba_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [scba_pkg::STATUS_W-1:0]   m_axis_tuser
);
  import scba_pkg::*;

  localparam int unsigned STACK_CAP = MAX_PAGES * MAX_SLOTS;
  localparam int unsigned TOP_W     = $clog2(STACK_CAP + 1);
  localparam int unsigned PG_W      = $clog2(MAX_PAGES + 1);
  localparam int unsigned FL_W      = $clog2(MAX_SLOTS + 1);
  localparam int unsigned META_W    = TOP_W + PG_W + FL_W;
  localparam int unsigned CLS_AW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned STK_DEPTH = NUM_CLASSES * STACK_CAP;
  localparam int unsigned SA_W      = $clog2(STK_DEPTH);
  localparam int unsigned PGX_W     = (PG_W > PAGE_W) ? PG_W : PAGE_W;
  localparam int unsigned FLX_W     = (FL_W > SLOT_W) ? FL_W : SLOT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_META = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0]          state_q, state_d;
  cmd_e                cmd_q;
  logic [SIZE_W-1:0]   size_q;
  logic                pooled_q;
  logic [PAGE_W-1:0]   rpage_q;
  logic [SLOT_W-1:0]   rslot_q;
  logic [CLASS_W-1:0]  cls_q;
  logic                over_q;

  logic [CLASS_W-1:0]  cls_in;
  logic                over_in;
  logic                accept;
  logic                can_emit;
  logic                emit;

  logic [META_W-1:0]   meta_rd, meta_wd;
  logic                meta_we;
  logic [TOP_W-1:0]    top;
  logic [PG_W-1:0]     pm, pm_new, page_val;
  logic [FL_W-1:0]     fl, fl_new, spp_raw, spp;
  logic [PGX_W-1:0]    pg_ext;
  logic [FLX_W-1:0]    fl_ext;

  logic [SA_W-1:0]     base, addr_top, addr_pop, stk_addr;
  logic                stk_re, stk_we;
  logic [ENTRY_W-1:0]  stk_rd;

  logic [SIZE_W-1:0]   bsize;
  status_e             res_st;
  logic [SIZE_W-1:0]   res_bs;
  logic [CLASS_W-1:0]  res_cls;
  logic [PAGE_W-1:0]   res_pg;
  logic [SLOT_W-1:0]   res_sl;
  logic                res_pl;
  logic                upd_meta, push, go_pop;

  status_e             ost_q, ost_d;
  logic [CLASS_W-1:0]  ocls_q, ocls_d;
  logic [SIZE_W-1:0]   obs_q, obs_d;
  logic [PAGE_W-1:0]   opg_q, opg_d;
  logic [SLOT_W-1:0]   osl_q, osl_d;
  logic                opl_q, opl_d;
  logic                ovalid_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign can_emit      = !ovalid_q || m_axis_tready;

  scba_size_class #(
    .NUM_CLASSES(NUM_CLASSES)
  ) u_class (
    .size_i    (s_axis_tdata[SIZE_W-1:0]),
    .class_o   (cls_in),
    .oversize_o(over_in)
  );

  scba_meta_mem #(
    .DEPTH(NUM_CLASSES),
    .AW   (CLS_AW),
    .W    (META_W)
  ) u_meta (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_addr_i(cls_in[CLS_AW-1:0]),
    .rd_data_o(meta_rd),
    .wr_en_i  (meta_we),
    .wr_addr_i(cls_q[CLS_AW-1:0]),
    .wr_data_i(meta_wd)
  );

  scba_stack_mem #(
    .DEPTH(STK_DEPTH),
    .AW   (SA_W),
    .W    (ENTRY_W)
  ) u_stack (
    .clk_i    (clk_i),
    .rd_en_i  (stk_re),
    .rd_addr_i(stk_addr),
    .rd_data_o(stk_rd),
    .wr_en_i  (stk_we),
    .wr_addr_i(stk_addr),
    .wr_data_i({rpage_q, rslot_q})
  );

  // metadata fields and derived values
  assign top      = meta_rd[META_W-1 -: TOP_W];
  assign pm       = meta_rd[FL_W +: PG_W];
  assign fl       = meta_rd[FL_W-1:0];
  assign bsize    = MIN_BLOCK << cls_q;
  assign spp_raw  = FL_W'(MAX_SLOTS) >> cls_q[CLASS_W-1:2];
  assign spp      = (spp_raw == '0) ? FL_W'(1) : spp_raw;
  assign pm_new   = (fl == '0) ? pm + PG_W'(1) : pm;
  assign fl_new   = ((fl == '0) ? spp : fl) - FL_W'(1);
  assign page_val = pm_new - PG_W'(1);
  assign pg_ext   = PGX_W'(page_val);
  assign fl_ext   = FLX_W'(fl_new);

  assign base     = SA_W'(cls_q[CLS_AW-1:0]) * SA_W'(STACK_CAP);
  assign addr_top = base + SA_W'(top);
  assign addr_pop = addr_top - SA_W'(1);
  assign stk_addr = go_pop ? addr_pop : addr_top;

  // decision on the metadata just read
  always_comb begin
    res_st   = ST_GRANT;
    res_cls  = cls_q;
    res_bs   = bsize;
    res_pg   = '0;
    res_sl   = '0;
    res_pl   = 1'b0;
    upd_meta = 1'b0;
    push     = 1'b0;
    go_pop   = 1'b0;
    meta_wd  = meta_rd;
    if (cmd_q == CMD_RELEASE && !pooled_q) begin
      res_st  = ST_UNPOOLED;
      res_cls = '0;
      res_bs  = size_q;
    end else if (over_q) begin
      res_st  = (cmd_q == CMD_ALLOC) ? ST_OVERSIZE : ST_INVALID;
      res_cls = '0;
      res_bs  = size_q;
    end else if (cmd_q == CMD_RELEASE) begin
      if (top >= TOP_W'(STACK_CAP)) begin
        res_st = ST_EXHAUSTED;
      end else begin
        res_st   = ST_RELEASED;
        res_pg   = rpage_q;
        res_sl   = rslot_q;
        res_pl   = 1'b1;
        push     = 1'b1;
        upd_meta = 1'b1;
        meta_wd  = {top + TOP_W'(1), pm, fl};
      end
    end else if (top != '0) begin
      go_pop  = 1'b1;
      meta_wd = {top - TOP_W'(1), pm, fl};
    end else if (fl == '0 && pm >= PG_W'(MAX_PAGES)) begin
      res_st = ST_EXHAUSTED;
    end else begin
      res_pg   = pg_ext[PAGE_W-1:0];
      res_sl   = fl_ext[SLOT_W-1:0];
      res_pl   = 1'b1;
      upd_meta = 1'b1;
      meta_wd  = {top, pm_new, fl_new};
    end
  end

  always_comb begin
    state_d = state_q;
    meta_we = 1'b0;
    stk_re  = 1'b0;
    stk_we  = 1'b0;
    emit    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_META;
        end
      end
      S_META: begin
        if (go_pop) begin
          stk_re  = 1'b1;
          meta_we = 1'b1;
          state_d = S_POP;
        end else if (can_emit) begin
          emit    = 1'b1;
          meta_we = upd_meta;
          stk_we  = push;
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        if (can_emit) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (state_q == S_POP) begin
      ost_d  = ST_GRANT;
      ocls_d = cls_q;
      obs_d  = bsize;
      opg_d  = stk_rd[SLOT_W +: PAGE_W];
      osl_d  = stk_rd[SLOT_W-1:0];
      opl_d  = 1'b1;
    end else begin
      ost_d  = res_st;
      ocls_d = res_cls;
      obs_d  = res_bs;
      opg_d  = res_pg;
      osl_d  = res_sl;
      opl_d  = res_pl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_e'(s_axis_tuser);
      size_q   <= s_axis_tdata[SIZE_W-1:0];
      pooled_q <= s_axis_tdata[SIZE_W];
      rpage_q  <= s_axis_tdata[SIZE_W+1 +: PAGE_W];
      rslot_q  <= s_axis_tdata[SIZE_W+1+PAGE_W +: SLOT_W];
      cls_q    <= cls_in;
      over_q   <= over_in;
    end
    if (emit) begin
      ost_q  <= ost_d;
      ocls_q <= ocls_d;
      obs_q  <= obs_d;
      opg_q  <= opg_d;
      osl_q  <= osl_d;
      opl_q  <= opl_d;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {opl_q, osl_q, opg_q, obs_q, ocls_q};
  assign m_axis_tuser  = ost_q;

endmodule
